// ===== design/periodic_task_scheduler_defines.svh =====
// Assertion macros shared by the periodic task scheduler checkers.
`ifndef PERIODIC_TASK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pts_pkg.sv =====
// Types and constants of the periodic task scheduler.
`default_nettype none

package pts_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int PRIO_LEVELS_DEF = 8;
    localparam int CD_W            = 16;
    localparam int PRIO_W          = 3;
    localparam int ID_W            = 4;
    localparam int REQ_W           = 2;
    localparam int STATUS_W        = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_PICK   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_MOVE,
        S_PEND
    } t_state;

    typedef struct packed {
        logic [CD_W-1:0] a;
        logic [CD_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic            lt;
        logic            eq;
        logic [CD_W-1:0] dec;
    } t_alu_rsp;

endpackage

`default_nettype wire

// ===== design/pts_alu.sv =====
// Shared compare and decrement unit of the periodic task scheduler.
`default_nettype none

module pts_alu (
    input  pts_pkg::t_alu_req i_req,
    output pts_pkg::t_alu_rsp o_rsp
);
    import pts_pkg::*;

    assign o_rsp.lt  = (i_req.a < i_req.b);
    assign o_rsp.eq  = (i_req.a == i_req.b);
    assign o_rsp.dec = i_req.b - CD_W'(1);

endmodule

`default_nettype wire

// ===== design/periodic_task_scheduler.sv =====
// Top level: task table, sequencer and result registers of the periodic task scheduler.
// After accept the sequencer passes a decode state, then walks the service-order entries
// (every entry for tick and pick, up to the match and then a move state for delete, none
// for add), then scans every slot for the pending priority before the o_done strobe.
// One word in flight; the next start is taken in the o_done cycle.
// Synchronous active-low reset empties the table and returns the sequencer to idle.
`default_nettype none

module periodic_task_scheduler #(
    parameter int SLOTS           = pts_pkg::SLOTS_DEF,
    parameter int PRIORITY_LEVELS = pts_pkg::PRIO_LEVELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    output logic                         o_done,
    input  logic [pts_pkg::REQ_W-1:0]    i_req_type,
    input  logic [pts_pkg::ID_W-1:0]     i_slot_id,
    input  logic [pts_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [pts_pkg::CD_W-1:0]     i_period,
    output logic [pts_pkg::STATUS_W-1:0] o_status,
    output logic [pts_pkg::ID_W-1:0]     o_new_id,
    output logic                         o_chosen_valid,
    output logic [pts_pkg::ID_W-1:0]     o_chosen_id,
    output logic                         o_pending_valid,
    output logic [pts_pkg::PRIO_W-1:0]   o_pending_priority
);
    import pts_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [PRIO_W-1:0] PMAX =
        (PRIORITY_LEVELS > 8) ? PRIO_W'(7) : PRIO_W'(PRIORITY_LEVELS - 1);
    localparam logic [CW-1:0]   SLOTS_C  = CW'(SLOTS);
    localparam logic [CW-1:0]   PEND_END = CW'(SLOTS - 1);
    localparam logic [ID_W-1:0] SLOTS_ID = ID_W'(SLOTS);

    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic [ID_W-1:0]     r_sid, n_sid;
    logic [PRIO_W-1:0]   r_prio, n_prio;
    logic [CD_W-1:0]     r_period, n_period;
    logic [SLOTS-1:0]    r_used, n_used;
    logic [SLOTS-1:0]    r_ready, n_ready;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_k, n_k;
    logic [IW-1:0]       r_hole, n_hole;
    logic                r_found, n_found;
    logic [IW-1:0]       r_best, n_best;
    logic [PRIO_W-1:0]   r_best_prio, n_best_prio;
    logic                r_done, n_done;
    t_status             r_status, n_status;
    logic [ID_W-1:0]     r_new_id, n_new_id;
    logic                r_cv, n_cv;
    logic [ID_W-1:0]     r_cid, n_cid;
    logic                r_pv, n_pv;
    logic [PRIO_W-1:0]   r_pp, n_pp;

    logic [PRIO_W-1:0]   r_slot_prio   [SLOTS];
    logic [CD_W-1:0]     r_slot_period [SLOTS];
    logic [CD_W-1:0]     r_countdown   [SLOTS];
    logic [IW-1:0]       r_order       [SLOTS];

    logic [IW-1:0]       k_idx;
    logic [CW-1:0]       last_c;
    logic [IW-1:0]       last_idx;
    logic [IW-1:0]       ord_raddr;
    logic [IW-1:0]       ord_rdata;
    logic [IW-1:0]       slot_idx;
    logic [PRIO_W-1:0]   cur_prio;
    logic [CD_W-1:0]     cur_cd;
    logic [CD_W-1:0]     cur_per;
    logic [ID_W-1:0]     sid_m1;
    logic [IW-1:0]       del_idx;
    logic [IW-1:0]       free_idx;
    logic                free_ok;
    logic                table_full;
    logic                walk_last;
    logic                pend_last;
    logic [PRIO_W-1:0]   sat_prio;
    logic                add_we;
    logic                cd_we;
    logic [CD_W-1:0]     cd_wdata;
    logic                order_we;
    logic [IW-1:0]       order_waddr;
    logic [IW-1:0]       order_wdata;
    t_alu_req            alu_req;
    t_alu_rsp            alu_rsp;

    pts_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign busy               = (r_state != S_IDLE);
    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_new_id           = r_new_id;
    assign o_chosen_valid     = r_cv;
    assign o_chosen_id        = r_cid;
    assign o_pending_valid    = r_pv;
    assign o_pending_priority = r_pp;

    assign k_idx      = r_k[IW-1:0];
    assign last_c     = r_count - CW'(1);
    assign last_idx   = last_c[IW-1:0];
    assign ord_raddr  = (r_state == S_MOVE) ? last_idx : k_idx;
    assign ord_rdata  = r_order[ord_raddr];
    assign slot_idx   = (r_state == S_PEND) ? k_idx : ord_rdata;
    assign cur_prio   = r_slot_prio[slot_idx];
    assign cur_cd     = r_countdown[slot_idx];
    assign cur_per    = r_slot_period[slot_idx];
    assign sid_m1     = r_sid - ID_W'(1);
    assign del_idx    = sid_m1[IW-1:0];
    assign walk_last  = (r_k == last_c);
    assign pend_last  = (r_k == PEND_END);
    assign sat_prio   = (i_priority_req > PMAX) ? PMAX : i_priority_req;
    assign table_full = !free_ok || (r_count >= SLOTS_C);

    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = IW'(i);
                free_ok  = 1'b1;
            end
        end
    end

    always_comb begin
        alu_req.a = '0;
        alu_req.b = '0;
        unique case (r_state)
            S_WALK: begin
                case (r_req)
                    REQ_TICK: begin
                        alu_req.a = CD_W'(1);
                        alu_req.b = cur_cd;
                    end
                    REQ_PICK: begin
                        alu_req.a = CD_W'(cur_prio);
                        alu_req.b = CD_W'(r_best_prio);
                    end
                    REQ_DELETE: begin
                        alu_req.a = CD_W'(ord_rdata);
                        alu_req.b = CD_W'(del_idx);
                    end
                    default: begin
                        alu_req.a = '0;
                        alu_req.b = '0;
                    end
                endcase
            end
            S_PEND: begin
                alu_req.a = CD_W'(cur_prio);
                alu_req.b = CD_W'(r_pp);
            end
            default: begin
                alu_req.a = '0;
                alu_req.b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_sid       = r_sid;
        n_prio      = r_prio;
        n_period    = r_period;
        n_used      = r_used;
        n_ready     = r_ready;
        n_count     = r_count;
        n_k         = r_k;
        n_hole      = r_hole;
        n_found     = r_found;
        n_best      = r_best;
        n_best_prio = r_best_prio;
        n_done      = 1'b0;
        n_status    = r_status;
        n_new_id    = r_new_id;
        n_cv        = r_cv;
        n_cid       = r_cid;
        n_pv        = r_pv;
        n_pp        = r_pp;
        add_we      = 1'b0;
        cd_we       = 1'b0;
        cd_wdata    = cur_per;
        order_we    = 1'b0;
        order_waddr = r_hole;
        order_wdata = ord_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req    = t_req'(i_req_type);
                    n_sid    = i_slot_id;
                    n_prio   = sat_prio;
                    n_period = i_period;
                    n_status = ST_OK;
                    n_new_id = '0;
                    n_cv     = 1'b0;
                    n_cid    = '0;
                    n_pv     = 1'b0;
                    n_pp     = '0;
                    n_k      = '0;
                    n_found  = 1'b0;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_req) inside
                    REQ_ADD: begin
                        if (table_full) begin
                            n_status = ST_FULL;
                        end else begin
                            add_we            = 1'b1;
                            n_used[free_idx]  = 1'b1;
                            n_ready[free_idx] = 1'b0;
                            order_we          = 1'b1;
                            order_waddr       = r_count[IW-1:0];
                            order_wdata       = free_idx;
                            n_count           = r_count + CW'(1);
                            n_new_id          = ID_W'(free_idx) + ID_W'(1);
                        end
                        n_state = S_PEND;
                    end
                    REQ_DELETE: begin
                        if (r_sid == '0 || r_sid > SLOTS_ID || !r_used[del_idx]) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_PEND;
                        end else if (r_count == '0) begin
                            n_used[del_idx]  = 1'b0;
                            n_ready[del_idx] = 1'b0;
                            n_state          = S_PEND;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    REQ_TICK, REQ_PICK: begin
                        n_state = (r_count == '0) ? S_PEND : S_WALK;
                    end
                endcase
            end
            S_WALK: begin
                case (r_req)
                    REQ_TICK: begin
                        if (r_used[slot_idx]) begin
                            cd_we = 1'b1;
                            if (alu_rsp.lt) begin
                                cd_wdata = alu_rsp.dec;
                            end else begin
                                cd_wdata          = cur_per;
                                n_ready[slot_idx] = 1'b1;
                            end
                        end
                    end
                    REQ_PICK: begin
                        if (r_used[slot_idx] && r_ready[slot_idx] && (!r_found || alu_rsp.lt)) begin
                            n_found     = 1'b1;
                            n_best      = slot_idx;
                            n_best_prio = cur_prio;
                        end
                        if (walk_last && n_found) begin
                            n_ready[n_best] = 1'b0;
                            n_cv            = 1'b1;
                            n_cid           = ID_W'(n_best) + ID_W'(1);
                        end
                    end
                    REQ_DELETE: begin
                        if (alu_rsp.eq) begin
                            n_hole  = k_idx;
                            n_state = S_MOVE;
                        end else if (walk_last) begin
                            n_used[del_idx]  = 1'b0;
                            n_ready[del_idx] = 1'b0;
                        end
                    end
                    default: begin
                        n_state = S_PEND;
                    end
                endcase
                if (walk_last) begin
                    n_k = '0;
                    if (n_state == S_WALK) begin
                        n_state = S_PEND;
                    end
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_MOVE: begin
                order_we         = 1'b1;
                order_waddr      = r_hole;
                order_wdata      = ord_rdata;
                n_count          = last_c;
                n_used[del_idx]  = 1'b0;
                n_ready[del_idx] = 1'b0;
                n_k              = '0;
                n_state          = S_PEND;
            end
            S_PEND: begin
                if (r_used[k_idx] && r_ready[k_idx] && (!r_pv || alu_rsp.lt)) begin
                    n_pv = 1'b1;
                    n_pp = cur_prio;
                end
                if (pend_last) begin
                    n_k     = '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_ADD;
            r_used  <= '0;
            r_ready <= '0;
            r_count <= '0;
            r_k     <= '0;
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
            r_used  <= n_used;
            r_ready <= n_ready;
            r_count <= n_count;
            r_k     <= n_k;
            r_found <= n_found;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sid       <= n_sid;
        r_prio      <= n_prio;
        r_period    <= n_period;
        r_hole      <= n_hole;
        r_best      <= n_best;
        r_best_prio <= n_best_prio;
        r_status    <= n_status;
        r_new_id    <= n_new_id;
        r_cv        <= n_cv;
        r_cid       <= n_cid;
        r_pv        <= n_pv;
        r_pp        <= n_pp;
        if (add_we) begin
            r_slot_prio[free_idx]   <= r_prio;
            r_slot_period[free_idx] <= r_period;
            r_countdown[free_idx]   <= r_period;
        end else if (cd_we) begin
            r_countdown[slot_idx] <= cd_wdata;
        end
        if (order_we) begin
            r_order[order_waddr] <= order_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== design/pts_checker.sv =====
// Port-level checker of the periodic task scheduler and its bind.
`default_nettype none
`include "periodic_task_scheduler_defines.svh"

module pts_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic [pts_pkg::STATUS_W-1:0] o_status,
    input logic [pts_pkg::ID_W-1:0]     o_new_id,
    input logic                         o_chosen_valid,
    input logic [pts_pkg::ID_W-1:0]     o_chosen_id,
    input logic                         o_pending_valid,
    input logic [pts_pkg::PRIO_W-1:0]   o_pending_priority
);
    import pts_pkg::*;

    `PTS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done, "accepted word did not make the block busy")
    `PTS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result word shown while busy")
    `PTS_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result word strobed twice")
    `PTS_ASSERT_IMP(a_chosen, i_clk, i_rst_n, o_done && o_chosen_valid, o_chosen_id != '0 && o_status == ST_OK && o_new_id == '0, "picked word is malformed")
    `PTS_ASSERT_IMP(a_pending, i_clk, i_rst_n, o_done && !o_pending_valid, o_pending_priority == '0, "pending priority without a ready task")

endmodule

bind periodic_task_scheduler pts_checker u_pts_checker (.*);

`default_nettype wire
